// ----- rtl/core/frac_pkg.sv -----
// shared types and constants for the fraction reduction block
// no dependencies
package frac_pkg;
  localparam int unsigned DataW = 64;
  localparam int unsigned CntW = 7;

  typedef logic [DataW-1:0] word_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel_gcd;
    logic div_sel_num;
    logic gcd_advance;
    logic save_num;
    logic save_den;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic a_zero;
    logic g_gt_one;
  } dp_stat_t;
endpackage

// ----- rtl/core/frac_divider.sv -----
// restoring serial divider, one quotient bit per cycle
// depends on frac_pkg
module frac_divider
  import frac_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t dividend,
  input  word_t divisor,
  output logic  done,
  output word_t quotient,
  output word_t remainder
);
  logic            running;
  logic [CntW-1:0] count;
  word_t           dsr;
  logic [DataW:0]  trial;
  word_t           rem_shift;

  assign rem_shift = {remainder[DataW-2:0], quotient[DataW-1]};
  assign trial = {1'b0, rem_shift} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count <= '0;
        dsr <= divisor;
        quotient <= dividend;
        remainder <= '0;
      end else if (running) begin
        // remainder top bit shifted out is checked too
        if (remainder[DataW-1] || !trial[DataW]) begin
          remainder <= trial[DataW-1:0];
          quotient <= {quotient[DataW-2:0], 1'b1};
        end else begin
          remainder <= rem_shift;
          quotient <= {quotient[DataW-2:0], 1'b0};
        end
        count <= count + 1'b1;
        if (count == CntW'(DataW - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/core/frac_datapath.sv -----
// operand registers, gcd loop registers and result registers
// depends on frac_pkg, frac_divider
module frac_datapath
  import frac_pkg::*;
(
  input  logic     clk,
  input  word_t    numerator,
  input  word_t    denominator,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  input  logic     rst,
  output word_t    reduced_numerator,
  output word_t    reduced_denominator,
  output word_t    common_divisor
);
  word_t num, den, a, b;
  word_t div_dividend, div_divisor, quo, rem;
  logic  div_done;

  always_comb begin
    if (cmd.div_sel_gcd) begin
      div_dividend = b;
      div_divisor = a;
    end else begin
      div_dividend = cmd.div_sel_num ? num : den;
      div_divisor = b;
    end
  end

  frac_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(div_dividend), .divisor(div_divisor),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num <= numerator;
      den <= denominator;
      a <= numerator;
      b <= denominator;
      reduced_numerator <= numerator;
      reduced_denominator <= denominator;
    end
    if (cmd.gcd_advance) begin
      b <= a;
      a <= rem;
    end
    if (cmd.save_num) reduced_numerator <= quo;
    if (cmd.save_den) reduced_denominator <= quo;
  end

  assign common_divisor = b;
  assign stat.div_done = div_done;
  assign stat.a_zero = (a == '0);
  assign stat.g_gt_one = (b > word_t'(1));
endmodule

// ----- rtl/core/frac_ctrl.sv -----
// controller sequencing euclid steps and the two final divisions
// depends on frac_pkg
module frac_ctrl
  import frac_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     done
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TEST = 3'd1;
  localparam logic [2:0] S_GCD  = 3'd2;
  localparam logic [2:0] S_NUM  = 3'd3;
  localparam logic [2:0] S_DEN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state, state_next;
  logic       issued, issued_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      issued <= issued_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    issued_next = issued;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        issued_next = 1'b0;
        if (stat.a_zero) state_next = stat.g_gt_one ? S_NUM : S_OUT;
        else state_next = S_GCD;
      end
      S_GCD: begin
        cmd.div_sel_gcd = 1'b1;
        if (!issued) begin
          cmd.div_start = 1'b1;
          issued_next = 1'b1;
        end else if (stat.div_done) begin
          cmd.gcd_advance = 1'b1;
          state_next = S_TEST;
        end
      end
      S_NUM: begin
        cmd.div_sel_num = 1'b1;
        if (!issued) begin
          cmd.div_start = 1'b1;
          issued_next = 1'b1;
        end else if (stat.div_done) begin
          cmd.save_num = 1'b1;
          issued_next = 1'b0;
          state_next = S_DEN;
        end
      end
      S_DEN: begin
        if (!issued) begin
          cmd.div_start = 1'b1;
          issued_next = 1'b1;
        end else if (stat.div_done) begin
          cmd.save_den = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule

// ----- rtl/core/fraction_reduce_u64.sv -----
// top level of the fraction reduction block
// depends on frac_pkg, frac_ctrl, frac_datapath
//
// Reduces one unsigned 64-bit fraction per command. Pulse start while busy is
// low; the operands are captured in that cycle and busy stays high until the
// result is shown for exactly one cycle with done high, which the receiver
// must take then. Each Euclid step is one modulo on a shared serial divider,
// followed by a zero test of the new remainder; when the divisor exceeds one
// two more divisions follow.
module fraction_reduce_u64
  import frac_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  input  word_t numerator,
  input  word_t denominator,
  output logic  done,
  output word_t reduced_numerator,
  output word_t reduced_denominator,
  output word_t common_divisor
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  frac_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat),
    .cmd(cmd), .busy(busy), .done(done)
  );

  frac_datapath u_dp (
    .clk(clk), .numerator(numerator), .denominator(denominator),
    .cmd(cmd), .stat(stat), .rst(rst),
    .reduced_numerator(reduced_numerator),
    .reduced_denominator(reduced_denominator),
    .common_divisor(common_divisor)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done outside busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer not taken");
endmodule

// ----- bench/tb_fraction_reduce_u64.sv -----
// testbench for fraction_reduce_u64: directed and random fractions checked
// against a built-in gcd reduction predictor; depends on frac_pkg and the rtl
`timescale 1ns / 1ps

module tb_fraction_reduce_u64;
  import frac_pkg::*;

  class frac_scoreboard;
    word_t exp_num[$];
    word_t exp_den[$];
    word_t exp_gcd[$];
    int errors;
    int checked;

    function new();
      errors = 0;
      checked = 0;
    endfunction

    function void note_transfer(word_t n, word_t d);
      word_t a;
      word_t b;
      word_t r;
      a = n;
      b = d;
      while (a != '0) begin
        r = b % a;
        b = a;
        a = r;
      end
      if (b > 64'd1) begin
        exp_num.push_back(n / b);
        exp_den.push_back(d / b);
      end else begin
        exp_num.push_back(n);
        exp_den.push_back(d);
      end
      exp_gcd.push_back(b);
    endfunction

    function void check_result(word_t n, word_t d, word_t g);
      word_t en;
      word_t ed;
      word_t eg;
      if (exp_num.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h/%h gcd %h", n, d, g);
        return;
      end
      en = exp_num.pop_front();
      ed = exp_den.pop_front();
      eg = exp_gcd.pop_front();
      checked++;
      if (n !== en || d !== ed || g !== eg) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp %h/%h gcd %h, got %h/%h gcd %h", en, ed, eg, n, d, g);
      end
    endfunction

    function int pending();
      return exp_num.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  word_t numerator;
  word_t denominator;
  logic done;
  word_t reduced_numerator;
  word_t reduced_denominator;
  word_t common_divisor;

  frac_scoreboard sb;
  int idle_pct;
  longint cycles;
  int sent;

  fraction_reduce_u64 i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .numerator(numerator),
    .denominator(denominator),
    .done(done),
    .reduced_numerator(reduced_numerator),
    .reduced_denominator(reduced_denominator),
    .common_divisor(common_divisor)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_result(reduced_numerator, reduced_denominator, common_divisor);
    if (cycles > 64'd3000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_frac(word_t n, word_t d);
    while ($urandom_range(99, 0) < idle_pct) @(posedge clk);
    start <= 1'b1;
    numerator <= n;
    denominator <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_transfer(n, d);
    sent++;
    start <= 1'b0;
    // wait with start low so the next drive lands in a later step
    @(posedge clk);
  endtask

  task automatic send_random();
    word_t g;
    word_t n;
    word_t d;
    int shift;
    case ($urandom_range(3, 0))
      0: send_frac(rand_word(), rand_word());
      1: begin
        shift = $urandom_range(30, 1);
        g = rand_word() >> (64 - shift);
        n = rand_word() >> shift;
        d = rand_word() >> shift;
        send_frac(n * g, d * g);
      end
      2: send_frac(rand_word() >> $urandom_range(63, 0), rand_word() >> $urandom_range(63, 0));
      default: begin
        n = word_t'($urandom_range(40, 0));
        d = word_t'($urandom_range(40, 0));
        send_frac(n, d);
      end
    endcase
  endtask

  initial begin
    sb = new();
    cycles = 0;
    sent = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    numerator = '0;
    denominator = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send_frac(64'd0, 64'd0);
    send_frac(64'd0, 64'd1);
    send_frac(64'd1, 64'd0);
    send_frac(64'd0, 64'd12);
    send_frac(64'd12, 64'd0);
    send_frac(64'd0, '1);
    send_frac('1, 64'd0);
    send_frac(64'd1, 64'd1);
    send_frac('1, '1);
    send_frac('1, 64'd1);
    send_frac(64'd1, '1);
    send_frac(64'd6, 64'd4);
    send_frac(64'd35, 64'd64);
    send_frac(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000);
    send_frac('1, 64'hFFFF_FFFF_FFFF_FFFE);
    // consecutive fibonacci numbers: longest euclid chain
    send_frac(64'd7540113804746346429, 64'd12200160415121876738);
    send_frac(64'd12200160415121876738, 64'd7540113804746346429);
    send_frac(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_frac(64'd1000000007 * 64'd3, 64'd1000000007 * 64'd5);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 71;
        2: idle_pct = 0;
        default: idle_pct = 25;
      endcase
      repeat (25) send_random();
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d fractions, %0d results checked", sent, sb.checked);
    $display("covered zero operands, coprime pairs, common factors and long chains");
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/frac_pkg.sv
rtl/core/frac_divider.sv
rtl/core/frac_datapath.sv
rtl/core/frac_ctrl.sv
rtl/core/fraction_reduce_u64.sv
bench/tb_fraction_reduce_u64.sv
